@@ hdl/mh_pkg.sv @@
// ---------------------------------------------------------------------------
// mh_pkg: shared types and constants for the MurmurHash64A engine
// Holds the mixing constant, field widths, controller states and the
// command and status records passed between controller and datapath.
// ---------------------------------------------------------------------------
package mh_pkg;

    localparam int WORD_W   = 64;
    localparam int HALF_W   = 32;
    localparam int NBYTES_W = 4;
    localparam int LEN_W    = 31;
    localparam int SEED_W   = 32;
    localparam int BYTES    = 8;
    localparam int SHIFT_R  = 47;

    localparam logic [WORD_W-1:0] MUL_M  = 64'hc6a4a7935bd1e995;
    localparam logic [HALF_W-1:0] MUL_LO = MUL_M[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MUL_HI = MUL_M[WORD_W-1:HALF_W];

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_A,
        S_INIT_B,
        S_DECIDE,
        S_KM1_A,
        S_KM1_B,
        S_KM2_A,
        S_KM2_B,
        S_TAIL,
        S_HM_A,
        S_HM_B,
        S_FIN,
        S_FM_A,
        S_FM_B,
        S_EMIT
    } state_t;

    // Operand that feeds the partial-product stage
    typedef enum logic [1:0] {
        MSRC_LEN,
        MSRC_WORD,
        MSRC_K,
        MSRC_HASH
    } mul_src_t;

    // Register update the datapath performs this cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_K_XS,
        OP_HASH_XOR,
        OP_HASH_SET,
        OP_TAIL,
        OP_FIN_XS,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic     capture;
        mul_src_t mul_src;
        dp_op_t   op;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic tail_zero;
        logic tail_full;
    } status_t;

    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
        return v ^ (v >> SHIFT_R);
    endfunction

    function automatic logic [WORD_W-1:0] tail_mask(input logic [NBYTES_W-1:0] nb);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < BYTES; i++)
        begin
            if (NBYTES_W'(i) < nb)
            begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

@@ hdl/mh_if.sv @@
// ---------------------------------------------------------------------------
// mh_if: request and result channels of the MurmurHash64A engine
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
interface mh_req_if;
    logic                          valid;
    logic                          ready;
    logic [mh_pkg::WORD_W-1:0]     word;
    logic [mh_pkg::NBYTES_W-1:0]   valid_bytes;
    logic                          is_first;
    logic                          is_last;
    logic [mh_pkg::LEN_W-1:0]      total_length;

    modport source (
        output valid, word, valid_bytes, is_first, is_last, total_length,
        input  ready
    );
    modport sink (
        input  valid, word, valid_bytes, is_first, is_last, total_length,
        output ready
    );
endinterface

interface mh_res_if;
    logic                      valid;
    logic                      ready;
    logic [mh_pkg::WORD_W-1:0] hash;

    modport source (
        output valid, hash,
        input  ready
    );
    modport sink (
        input  valid, hash,
        output ready
    );
endinterface

@@ hdl/murmur2_64a_hash.sv @@
// ---------------------------------------------------------------------------
// murmur2_64a_hash: streaming MurmurHash64A engine
// Hashes a message delivered as little-endian 64-bit words and returns the
// finalized 64-bit hash on the last word of each message.
//
//   channel   dir   handshake          payload
//   msg       in    valid / ready      word, valid_bytes, is_first,
//                                      is_last, total_length
//   res       out   valid / ready      hash
//   cfg       in    cfg_we             cfg_wdata (seed)
//
// Sequencing: requests are accepted only while idle, one word at a time. A
// first word adds the seed init; a last word adds finalization, a tail step
// for a 1 to 7 byte tail, none for an empty one. Each product by M is a
// registered partial-product step followed by the combining add.
// Reset: rst_n clears the running hash, the seed and the controller.
// Stalls: a finished hash waits in the result register; the next request is
// accepted meanwhile, and only a later emit waits for the register to free.
// ---------------------------------------------------------------------------
module murmur2_64a_hash (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [mh_pkg::SEED_W-1:0] cfg_wdata,
    mh_req_if.sink                    msg,
    mh_res_if.source                  res
);

    // command and status between sequencer and datapath
    mh_pkg::cmd_t    cmd;
    mh_pkg::status_t status;

    // Sequencer: walks each request through init, mix, tail and finalize steps
    mh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (msg.valid),
        .req_ready (msg.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: request capture, running hash, mixing multiplier, result
    mh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .word         (msg.word),
        .valid_bytes  (msg.valid_bytes),
        .is_first     (msg.is_first),
        .is_last      (msg.is_last),
        .total_length (msg.total_length),
        .cmd          (cmd),
        .status       (status),
        .hash         (res.hash)
    );

endmodule

@@ hdl/mh_datapath.sv @@
// ---------------------------------------------------------------------------
// mh_datapath: registers and 64-bit modular multiplier of the hash engine
// Runs one command per cycle; a product by the mixing constant is split into
// registered partial products, then the combining add.
// ---------------------------------------------------------------------------
module mh_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mh_pkg::SEED_W-1:0]     cfg_wdata,
    input  logic [mh_pkg::WORD_W-1:0]     word,
    input  logic [mh_pkg::NBYTES_W-1:0]   valid_bytes,
    input  logic                          is_first,
    input  logic                          is_last,
    input  logic [mh_pkg::LEN_W-1:0]      total_length,
    input  mh_pkg::cmd_t                  cmd,
    output mh_pkg::status_t               status,
    output logic [mh_pkg::WORD_W-1:0]     hash
);

    logic [mh_pkg::SEED_W-1:0]   seed_reg;
    logic [mh_pkg::WORD_W-1:0]   hash_reg;
    logic [mh_pkg::WORD_W-1:0]   hash_next;
    logic [mh_pkg::WORD_W-1:0]   k_reg;
    logic [mh_pkg::WORD_W-1:0]   word_reg;
    logic [mh_pkg::NBYTES_W-1:0] nb_reg;
    logic                        first_reg;
    logic                        last_reg;
    logic [mh_pkg::LEN_W-1:0]    len_reg;
    logic [mh_pkg::WORD_W-1:0]   res_reg;

    logic [mh_pkg::WORD_W-1:0]   op;
    logic [mh_pkg::WORD_W-1:0]   pp0;
    logic [mh_pkg::HALF_W-1:0]   pp1;
    logic [mh_pkg::HALF_W-1:0]   pp2;
    logic [mh_pkg::WORD_W-1:0]   pp0_reg;
    logic [mh_pkg::HALF_W-1:0]   pp1_reg;
    logic [mh_pkg::HALF_W-1:0]   pp2_reg;
    logic [mh_pkg::HALF_W-1:0]   cross_sum;
    logic [mh_pkg::WORD_W-1:0]   prod;

    // Operand select and partial products (low 64 bits of op * M)
    always_comb
    begin
        case (cmd.mul_src)
            mh_pkg::MSRC_LEN:  op = mh_pkg::WORD_W'(len_reg);
            mh_pkg::MSRC_WORD: op = word_reg;
            mh_pkg::MSRC_K:    op = k_reg;
            mh_pkg::MSRC_HASH: op = hash_reg;
            default:           op = hash_reg;
        endcase
    end

    assign pp0   = mh_pkg::WORD_W'(op[mh_pkg::HALF_W-1:0])
                 * mh_pkg::WORD_W'(mh_pkg::MUL_LO);
    assign pp1   = op[mh_pkg::HALF_W-1:0] * mh_pkg::MUL_HI;
    assign pp2   = op[mh_pkg::WORD_W-1:mh_pkg::HALF_W] * mh_pkg::MUL_LO;
    assign cross_sum = pp1_reg + pp2_reg;
    assign prod  = pp0_reg + {cross_sum, mh_pkg::HALF_W'(0)};

    always_ff @(posedge clk)
    begin
        pp0_reg <= pp0;
        pp1_reg <= pp1;
        pp2_reg <= pp2;
    end

    always_comb
    begin
        case (cmd.op)
            mh_pkg::OP_INIT:     hash_next = mh_pkg::WORD_W'(seed_reg) ^ prod;
            mh_pkg::OP_HASH_XOR: hash_next = hash_reg ^ prod;
            mh_pkg::OP_HASH_SET: hash_next = prod;
            mh_pkg::OP_TAIL:     hash_next = hash_reg ^ (word_reg & mh_pkg::tail_mask(nb_reg));
            default:             hash_next = hash_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            hash_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            hash_reg <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            word_reg  <= word;
            nb_reg    <= valid_bytes;
            first_reg <= is_first;
            last_reg  <= is_last;
            len_reg   <= total_length;
        end
        case (cmd.op)
            mh_pkg::OP_K_XS:   k_reg <= mh_pkg::xorshift(prod);
            mh_pkg::OP_FIN_XS: k_reg <= mh_pkg::xorshift(hash_reg);
            default:           k_reg <= k_reg;
        endcase
        if (cmd.op == mh_pkg::OP_EMIT)
        begin
            res_reg <= k_reg;
        end
    end

    always_comb
    begin
        status.first     = first_reg;
        status.last      = last_reg;
        status.tail_zero = (nb_reg == '0);
        status.tail_full = nb_reg inside {[4'd8:4'd15]};
    end

    assign hash = res_reg;

endmodule

@@ hdl/mh_ctrl.sv @@
// ---------------------------------------------------------------------------
// mh_ctrl: sequencer of the MurmurHash64A engine
// Steps each request through init, word mix, tail and finalization, and
// owns the result valid flag.
// ---------------------------------------------------------------------------
module mh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            res_valid,
    input  logic            res_ready,
    input  mh_pkg::status_t status,
    output mh_pkg::cmd_t    cmd
);

    mh_pkg::state_t state_reg;
    mh_pkg::state_t state_next;
    logic           res_valid_reg;
    logic           res_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mh_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.mul_src    = mh_pkg::MSRC_HASH;
        cmd.op         = mh_pkg::OP_NONE;
        req_ready      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;
        case (state_reg)
            mh_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = mh_pkg::S_INIT_A;
                end
            end
            mh_pkg::S_INIT_A:
            begin
                cmd.mul_src = mh_pkg::MSRC_LEN;
                state_next  = status.first ? mh_pkg::S_INIT_B : mh_pkg::S_DECIDE;
            end
            mh_pkg::S_INIT_B:
            begin
                cmd.op     = mh_pkg::OP_INIT;
                state_next = mh_pkg::S_DECIDE;
            end
            mh_pkg::S_DECIDE:
            begin
                if (!status.last || status.tail_full)
                begin
                    state_next = mh_pkg::S_KM1_A;
                end
                else if (status.tail_zero)
                begin
                    state_next = mh_pkg::S_FIN;
                end
                else
                begin
                    state_next = mh_pkg::S_TAIL;
                end
            end
            mh_pkg::S_KM1_A:
            begin
                cmd.mul_src = mh_pkg::MSRC_WORD;
                state_next  = mh_pkg::S_KM1_B;
            end
            mh_pkg::S_KM1_B:
            begin
                cmd.op     = mh_pkg::OP_K_XS;
                state_next = mh_pkg::S_KM2_A;
            end
            mh_pkg::S_KM2_A:
            begin
                cmd.mul_src = mh_pkg::MSRC_K;
                state_next  = mh_pkg::S_KM2_B;
            end
            mh_pkg::S_KM2_B:
            begin
                cmd.op     = mh_pkg::OP_HASH_XOR;
                state_next = mh_pkg::S_HM_A;
            end
            mh_pkg::S_TAIL:
            begin
                cmd.op     = mh_pkg::OP_TAIL;
                state_next = mh_pkg::S_HM_A;
            end
            mh_pkg::S_HM_A:
            begin
                cmd.mul_src = mh_pkg::MSRC_HASH;
                state_next  = mh_pkg::S_HM_B;
            end
            mh_pkg::S_HM_B:
            begin
                cmd.op     = mh_pkg::OP_HASH_SET;
                state_next = status.last ? mh_pkg::S_FIN : mh_pkg::S_IDLE;
            end
            mh_pkg::S_FIN:
            begin
                cmd.op     = mh_pkg::OP_FIN_XS;
                state_next = mh_pkg::S_FM_A;
            end
            mh_pkg::S_FM_A:
            begin
                cmd.mul_src = mh_pkg::MSRC_K;
                state_next  = mh_pkg::S_FM_B;
            end
            mh_pkg::S_FM_B:
            begin
                cmd.op     = mh_pkg::OP_K_XS;
                state_next = mh_pkg::S_EMIT;
            end
            mh_pkg::S_EMIT:
            begin
                // hold until the result register is free
                if (!res_valid_reg || res_ready)
                begin
                    cmd.op         = mh_pkg::OP_EMIT;
                    res_valid_next = 1'b1;
                    state_next     = mh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mh_pkg::S_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;

endmodule

@@ hdl/mh_checker.sv @@
// ---------------------------------------------------------------------------
// mh_checker: port-level checks for the MurmurHash64A engine
// Watches the request and result channels of the top level.
// ---------------------------------------------------------------------------
module mh_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      msg_valid,
    input logic                      msg_ready,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [mh_pkg::WORD_W-1:0] res_hash
);

    // a stalled result holds its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_hash))
        else $error("result dropped or changed while stalled");

    // one request in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |=> !msg_ready)
        else $error("request taken while previous one in flight");

    // a new result comes only from work in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !$past(msg_ready))
        else $error("result appeared while engine was idle");

    // an accepted request does not raise a result straight away
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |=> !$rose(res_valid))
        else $error("result raised right after request");

endmodule

bind murmur2_64a_hash mh_checker u_mh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_hash  (res.hash)
);
